// ===== src/spfc_pkg.sv =====
// Shared types, constants and CRC-8 helper for the sample packet framer.
// No dependencies; used by every module in src.
`default_nettype none
package spfc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SEQ_W     = 32;
	localparam int PAYLOAD_W = SAMPLE_W + SEQ_W;
	localparam int FRAME_LEN = 10;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [7:0] END_MARK    = 8'hFF;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] CRC_INIT    = 8'h00;

	// frame byte positions
	localparam logic [IDX_W-1:0] IDX_SYNC0 = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_SYNC1 = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_SMP0  = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_SMP1  = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_SEQ0  = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_SEQ1  = IDX_W'(5);
	localparam logic [IDX_W-1:0] IDX_SEQ2  = IDX_W'(6);
	localparam logic [IDX_W-1:0] IDX_SEQ3  = IDX_W'(7);
	localparam logic [IDX_W-1:0] IDX_CRC   = IDX_W'(8);
	localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(9);

	// payload in frame order: byte 0 is the sample low byte
	typedef logic [PAYLOAD_W-1:0] payload_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/spfc_front.sv =====
// Front end: takes input items, packs them into frame-order payload words.
// Depends on spfc_pkg.
`default_nettype none
module spfc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	input  wire logic [spfc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [spfc_pkg::SEQ_W-1:0]    sequence_number,
	input  wire spfc_pkg::q_stat_t            q_stat,
	output logic                              push,
	output spfc_pkg::payload_t                push_data
);

	logic               valid_s1;
	spfc_pkg::payload_t payload_s1;
	logic               accept;

	// hold the staged item while the queue is full
	assign sample_stall = valid_s1 && q_stat.full;
	assign accept       = sample_valid && !sample_stall;
	assign push         = valid_s1 && !q_stat.full;
	assign push_data    = payload_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			payload_s1 <= {sequence_number, sample};
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |=> valid_s1)
		else $error("staged item lost while stalled");
	a_stall_keeps_data: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_stat.full) |=> $stable(payload_s1))
		else $error("staged payload changed while queue full");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

endmodule
`default_nettype wire

// ===== src/spfc_queue.sv =====
// Two-entry payload queue between front and back ends.
// Depends on spfc_pkg.
`default_nettype none
module spfc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire spfc_pkg::payload_t push_data,
	input  wire logic               pop,
	output spfc_pkg::payload_t      head,
	output spfc_pkg::q_stat_t       q_stat
);

	spfc_pkg::payload_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_pop;

	assign q_stat.not_empty = (count_q != 2'd0);
	assign q_stat.full      = (count_q == 2'd2);
	assign head             = entry_q[rd_ptr_q];
	assign do_pop           = pop && q_stat.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_ptrs_match: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == 2'd0) || (count_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== src/spfc_back.sv =====
// Back end: serializes one queued payload into the ten-byte frame,
// running CRC-8 one byte per unstalled cycle. Depends on spfc_pkg.
`default_nettype none
module spfc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire spfc_pkg::payload_t head,
	input  wire spfc_pkg::q_stat_t  q_stat,
	output logic                    pop,
	output logic                    byte_valid,
	input  wire logic               byte_stall,
	output logic [7:0]              frame_byte,
	output logic                    last_byte
);

	logic [spfc_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                 crc_q;
	logic                       out_valid_q;
	logic [7:0]                 byte_q;
	logic                       last_q;
	logic                       load;
	logic [7:0]                 next_byte;
	logic                       in_payload;

	assign load = q_stat.not_empty && (!out_valid_q || !byte_stall);
	assign pop  = load && (idx_q == spfc_pkg::IDX_END);

	always_comb begin
		in_payload = 1'b1;
		case (idx_q)
			spfc_pkg::IDX_SYNC0: begin next_byte = spfc_pkg::SYNC_FIRST;  in_payload = 1'b0; end
			spfc_pkg::IDX_SYNC1: begin next_byte = spfc_pkg::SYNC_SECOND; in_payload = 1'b0; end
			spfc_pkg::IDX_SMP0:  next_byte = head[7:0];
			spfc_pkg::IDX_SMP1:  next_byte = head[15:8];
			spfc_pkg::IDX_SEQ0:  next_byte = head[23:16];
			spfc_pkg::IDX_SEQ1:  next_byte = head[31:24];
			spfc_pkg::IDX_SEQ2:  next_byte = head[39:32];
			spfc_pkg::IDX_SEQ3:  next_byte = head[47:40];
			spfc_pkg::IDX_CRC:   begin next_byte = crc_q;                 in_payload = 1'b0; end
			default:             begin next_byte = spfc_pkg::END_MARK;    in_payload = 1'b0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= spfc_pkg::IDX_SYNC0;
			crc_q       <= spfc_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (idx_q == spfc_pkg::IDX_END) begin
					idx_q <= spfc_pkg::IDX_SYNC0;
					crc_q <= spfc_pkg::CRC_INIT;
				end else begin
					idx_q <= idx_q + spfc_pkg::IDX_W'(1);
					if (in_payload) begin
						crc_q <= spfc_pkg::crc_feed(crc_q, next_byte);
					end
				end
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			last_q <= (idx_q == spfc_pkg::IDX_END);
		end
	end

	assign byte_valid = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= spfc_pkg::IDX_END)
		else $error("frame index out of range");
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (byte_q == spfc_pkg::END_MARK))
		else $error("last byte is not the end marker");
	a_crc_clear_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q == spfc_pkg::IDX_SYNC0) |-> (crc_q == spfc_pkg::CRC_INIT))
		else $error("CRC not cleared at frame start");
	a_pop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && last_q))
		else $error("pop without end marker");

endmodule
`default_nettype wire

// ===== src/sample_packet_framer_crc8.sv =====
// Sample packet framer: each accepted item (sample, sequence_number) becomes a
// ten-byte frame AA 55, sample LE, sequence LE, CRC-8 (poly 07, init 00), FF, sent
// one byte per cycle while byte_stall is low, with last_byte on the FF. An item
// passes through the front-end staging register and a queue entry, and its bytes
// leave from the back-end output register. New items are accepted while a frame
// is sent; a staging register and a two-entry queue let up to three items wait
// while the output side is stalled. No configuration, no reset-time sweep.
`default_nettype none
module sample_packet_framer_crc8 (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic [spfc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [spfc_pkg::SEQ_W-1:0]    sequence_number,
	output logic                               byte_valid,
	input  wire logic                          byte_stall,
	output logic [7:0]                         frame_byte,
	output logic                               last_byte
);

	spfc_pkg::q_stat_t  q_stat;
	spfc_pkg::payload_t push_data;
	spfc_pkg::payload_t head;
	logic               push;
	logic               pop;

	spfc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.sequence_number (sequence_number),
		.q_stat          (q_stat),
		.push            (push),
		.push_data       (push_data)
	);

	spfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	spfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
`default_nettype wire
